FILE: rtl/esched_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esched_pkg
// Shared types and constants of the elevator stop scheduler: event codes,
// command codes and the job word queued between front and back end.
// ----------------------------------------------------------------------------
package esched_pkg;

  localparam int FLOORS_DEF = 16;   // default number of floors
  localparam int FLOOR_W    = 4;    // width of a floor number
  localparam int CAR_W      = 2;    // width of the car identifier
  localparam int OP_W       = 3;
  localparam int CMD_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INIT    = 3'd0,
    OP_ARRIVED = 3'd1,
    OP_OPENED  = 3'd2,
    OP_CLOSED  = 3'd3,
    OP_INNER   = 3'd4,
    OP_OUTER   = 3'd5
  } op_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_READY     = 3'd0,
    CMD_STOP      = 3'd1,
    CMD_OPEN      = 3'd2,
    CMD_LIGHT_OFF = 3'd3,
    CMD_LIGHT_ON  = 3'd4,
    CMD_CLOSE     = 3'd5,
    CMD_UP        = 3'd6,
    CMD_DOWN      = 3'd7
  } cmd_e;

  // One classified event: up to three commands and the floor for lights
  typedef struct packed {
    logic [1:0]         cnt;
    cmd_e               cmd0;
    cmd_e               cmd1;
    cmd_e               cmd2;
    logic [FLOOR_W-1:0] tgt;
  } job_t;

  // Queue status seen by the two ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/esched_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esched_front
// Event front end: keeps the car state, classifies each accepted event and
// turns it into a job word of up to three commands for the queue.
// ----------------------------------------------------------------------------
module esched_front #(
  parameter int FLOORS = esched_pkg::FLOORS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  logic [esched_pkg::OP_W-1:0]    op_i,
  input  logic [esched_pkg::FLOOR_W-1:0] floor_i,
  output logic                         push_o,
  output esched_pkg::job_t             job_o
);
  import esched_pkg::*;

  localparam int FIDX_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;

  logic [FLOORS-1:0]  req_q, req_d;
  logic [FLOOR_W-1:0] cur_q, cur_d;
  logic               door_q, door_d;
  logic               down_q, down_d;

  logic              fl_ok;
  logic [FIDX_W-1:0] fidx;
  logic              req_hit;
  logic              above, below;
  logic              here;
  job_t              job;

  // Decode the floor operand
  assign fl_ok   = (32'(floor_i) < 32'(FLOORS));
  assign fidx    = FIDX_W'(floor_i);
  assign req_hit = fl_ok && req_q[fidx];
  assign here    = (floor_i == cur_q);

  // Scan pending requests against the current floor
  always_comb begin
    above = 1'b0;
    below = 1'b0;
    for (int i = 0; i < FLOORS; i++) begin
      if (req_q[i] && (32'(i) > 32'(cur_q))) above = 1'b1;
      if (req_q[i] && (32'(i) < 32'(cur_q))) below = 1'b1;
    end
  end

  // Classify the event and compute next car state
  always_comb begin
    req_d    = req_q;
    cur_d    = cur_q;
    door_d   = door_q;
    down_d   = down_q;
    job.cnt  = 2'd0;
    job.cmd0 = CMD_READY;
    job.cmd1 = CMD_READY;
    job.cmd2 = CMD_READY;
    job.tgt  = '0;
    unique case (op_e'(op_i))
      OP_INIT: begin
        job.cnt = 2'd1;
      end
      OP_ARRIVED: begin
        cur_d = floor_i;
        if (req_hit) begin
          req_d[fidx] = 1'b0;
          job.cnt     = 2'd3;
          job.cmd0    = CMD_STOP;
          job.cmd1    = CMD_OPEN;
          job.cmd2    = CMD_LIGHT_OFF;
          job.tgt     = floor_i;
        end
      end
      OP_OPENED: begin
        door_d = 1'b1;
        if (|req_q) begin
          job.cnt  = 2'd1;
          job.cmd0 = CMD_CLOSE;
        end
      end
      OP_CLOSED: begin
        door_d = 1'b0;
        if (!above)      down_d = 1'b1;
        else if (!below) down_d = 1'b0;
        job.cnt  = 2'd1;
        job.cmd0 = down_d ? CMD_DOWN : CMD_UP;
      end
      OP_INNER: begin
        if (fl_ok && !here) begin
          job.cnt  = 2'd1;
          job.cmd0 = CMD_LIGHT_ON;
          job.cmd1 = CMD_CLOSE;
          job.tgt  = floor_i;
          if (!req_q[fidx]) begin
            req_d[fidx] = 1'b1;
            if (door_q) job.cnt = 2'd2;
          end
        end
      end
      OP_OUTER: begin
        if (fl_ok && !here && !req_q[fidx]) begin
          req_d[fidx] = 1'b1;
          if (door_q) begin
            job.cnt  = 2'd1;
            job.cmd0 = CMD_CLOSE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign push_o = acc_i && (job.cnt != 2'd0);
  assign job_o  = job;

  // Update car state on accepted events
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q  <= '0;
      cur_q  <= '0;
      door_q <= 1'b0;
      down_q <= 1'b0;
    end else if (acc_i) begin
      req_q  <= req_d;
      cur_q  <= cur_d;
      door_q <= door_d;
      down_q <= down_d;
    end
  end

endmodule

FILE: rtl/esched_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esched_queue
// Two-entry job queue between the event front end and the command back end.
// ----------------------------------------------------------------------------
module esched_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  esched_pkg::job_t     job_i,
  input  logic                 pop_i,
  output esched_pkg::job_t     head_o,
  output esched_pkg::q_stat_t  stat_o
);
  import esched_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign head_o       = mem_q[rptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= job_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      priority if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i)     cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

FILE: rtl/esched_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esched_back
// Command back end: takes one job at a time from the queue and sends its
// commands one word per cycle when not stalled, via a registered output stage.
// ----------------------------------------------------------------------------
module esched_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [esched_pkg::CAR_W-1:0]   car_id_i,
  input  esched_pkg::job_t               head_i,
  input  esched_pkg::q_stat_t            stat_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [esched_pkg::CAR_W-1:0]   unit_o,
  output logic [esched_pkg::CMD_W-1:0]   command_o,
  output logic [esched_pkg::FLOOR_W-1:0] target_floor_o,
  output logic                           last_o
);
  import esched_pkg::*;

  job_t               job_q;
  logic               busy_q;
  logic [1:0]         idx_q;
  logic               oval_q;
  logic [CAR_W-1:0]   unit_q;
  cmd_e               cmd_q;
  logic [FLOOR_W-1:0] tgt_q;
  logic               last_q;

  logic load;
  cmd_e cur_cmd;
  logic is_last;

  // Fetch a job when idle, send a word when the output stage frees up
  assign pop_o   = !busy_q && !stat_i.empty;
  assign load    = busy_q && (!oval_q || !out_stall_i);
  assign is_last = (idx_q == (job_q.cnt - 2'd1));

  always_comb begin
    unique case (idx_q)
      2'd0:    cur_cmd = job_q.cmd0;
      2'd1:    cur_cmd = job_q.cmd1;
      default: cur_cmd = job_q.cmd2;
    endcase
  end

  // Job sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (load) begin
      idx_q <= idx_q + 2'd1;
      if (is_last) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= head_i;
  end

  // Output stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (load) begin
      oval_q <= 1'b1;
    end else if (!out_stall_i) begin
      oval_q <= 1'b0;
    end
  end

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      unit_q <= car_id_i;
      cmd_q  <= cur_cmd;
      tgt_q  <= (cur_cmd == CMD_LIGHT_ON || cur_cmd == CMD_LIGHT_OFF) ? job_q.tgt : '0;
      last_q <= is_last;
    end
  end

  assign out_valid_o    = oval_q;
  assign unit_o         = unit_q;
  assign command_o      = cmd_q;
  assign target_floor_o = tgt_q;
  assign last_o         = last_q;

endmodule

FILE: rtl/elevator_stop_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_stop_scheduler
// Single-car elevator controller: decoded events in, car commands out.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid_i/in_stall_o | op_i, floor_i
//   out     | output    | out_valid_o/out_stall_i | unit_o, command_o,
//           |           |                       | target_floor_o, last_o
//   cfg     | input     | cfg_we_i              | cfg_data_i (car id)
//
// An event is taken whenever the two-entry job queue has room.
// The back end fetches a job and sends its commands one at a time, taking
// the next job only after the last word; the command sequencer sets the rate.
// An event's first command passes the queue, job register and output stage.
// Reset clears all requests, floor, door, direction, car id and the queue.
// A stalled output holds its word; a full queue stalls the input.
// ----------------------------------------------------------------------------
module elevator_stop_scheduler #(
  parameter int FLOORS = esched_pkg::FLOORS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [esched_pkg::OP_W-1:0]    op_i,
  input  logic [esched_pkg::FLOOR_W-1:0] floor_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [esched_pkg::CAR_W-1:0]   unit_o,
  output logic [esched_pkg::CMD_W-1:0]   command_o,
  output logic [esched_pkg::FLOOR_W-1:0] target_floor_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic [esched_pkg::CAR_W-1:0]   cfg_data_i
);
  import esched_pkg::*;

  logic             acc;
  logic             push;
  logic             pop;
  job_t             job;
  job_t             head;
  q_stat_t          stat;
  logic [CAR_W-1:0] car_id_q;

  assign in_stall_o = stat.full;
  assign acc        = in_valid_i && !stat.full;

  // Car id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_id_q <= '0;
    end else if (cfg_we_i) begin
      car_id_q <= cfg_data_i;
    end
  end

  esched_front #(
    .FLOORS (FLOORS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .op_i    (op_i),
    .floor_i (floor_i),
    .push_o  (push),
    .job_o   (job)
  );

  esched_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  esched_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .car_id_i       (car_id_q),
    .head_i         (head),
    .stat_i         (stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .unit_o         (unit_o),
    .command_o      (command_o),
    .target_floor_o (target_floor_o),
    .last_o         (last_o)
  );

endmodule

FILE: rtl/esched_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esched_checker
// Port-level checks on the command stream of the elevator stop scheduler.
// ----------------------------------------------------------------------------
module esched_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [esched_pkg::CMD_W-1:0]   command_o,
  input logic [esched_pkg::FLOOR_W-1:0] target_floor_o,
  input logic                           last_o
);
  import esched_pkg::*;

  // Hold a stalled word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(command_o))
    else $error("stalled command word dropped or changed");

  // Ready is always a single-word answer
  a_ready_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == CMD_READY |-> last_o)
    else $error("ready not marked last");

  // Floor field only on light commands
  a_tgt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o != CMD_LIGHT_ON && command_o != CMD_LIGHT_OFF
      |-> target_floor_o == '0)
    else $error("target floor set on a non-light command");

  // Stop is followed at once by open
  a_stop_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && command_o == CMD_STOP
      |=> out_valid_o && command_o == CMD_OPEN && !last_o)
    else $error("stop not followed by open");

endmodule

bind elevator_stop_scheduler esched_checker u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .command_o      (command_o),
  .target_floor_o (target_floor_o),
  .last_o         (last_o)
);

FILE: test/elevator_stop_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_stop_scheduler_tb
// Self-checking bench for the single-car stop scheduler. A directed run walks
// every event and command, button and floor extremes, repeated presses and
// the three ways a door close picks a direction. Random trips follow: button
// presses, a door close, arrivals mostly at requested floors, and door cycles,
// mixed with raw noise events and undefined codes. An in-bench car model
// predicts each command word, and a monitor checks them in order. The car id
// moves through all its values between phases, and both channels idle and
// stall at random except in one long phase without gaps.
// ----------------------------------------------------------------------------
module elevator_stop_scheduler_tb;
  import esched_pkg::*;

  localparam int NUM_FLOORS = FLOORS_DEF;
  localparam int SETTLE_CYCLES = 12;      // job queue plus sequencer depth
  localparam int CYCLE_LIMIT = 200000;

  // One command word as the car emits it
  typedef struct packed {
    logic [CAR_W-1:0]   unit;
    cmd_e               cmd;
    logic [FLOOR_W-1:0] tgt;
    logic               last;
  } car_cmd_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    op;
  logic [FLOOR_W-1:0] floor_no;
  logic               out_valid;
  logic               out_stall;
  logic [CAR_W-1:0]   unit;
  logic [CMD_W-1:0]   command;
  logic [FLOOR_W-1:0] target_floor;
  logic               last;
  logic               cfg_we;
  logic [CAR_W-1:0]   cfg_data;

  // Car model state
  logic [NUM_FLOORS-1:0] pending_stops;
  logic [FLOOR_W-1:0]    car_floor;
  logic                  door_is_open;
  logic                  heading_down;
  logic [CAR_W-1:0]      car_unit;

  car_cmd_t cmd_due_q[$];
  bit       gaps_on;
  int       events_sent;
  int       mismatches;
  int       cycle_count;

  elevator_stop_scheduler #(
    .FLOORS(NUM_FLOORS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (op),
    .floor_i       (floor_no),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .unit_o        (unit),
    .command_o     (command),
    .target_floor_o(target_floor),
    .last_o        (last),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data)
  );

  // Free-running clock
  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands outstanding",
               cycle_count, cmd_due_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stall the command channel at random while gaps are on
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 29);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Work out the commands one accepted event causes and queue them
  function automatic void predict_commands(input logic [OP_W-1:0] op_v,
                                           input logic [FLOOR_W-1:0] fl);
    car_cmd_t step_q[$];
    logic     above;
    logic     below;
    logic     in_range;
    above = 1'b0;
    below = 1'b0;
    in_range = int'(fl) < NUM_FLOORS;
    case (op_v)
      OP_INIT: begin
        step_q.push_back('{car_unit, CMD_READY, 4'd0, 1'b0});
      end
      OP_ARRIVED: begin
        car_floor = fl;
        if (in_range && pending_stops[fl]) begin
          pending_stops[fl] = 1'b0;
          step_q.push_back('{car_unit, CMD_STOP, 4'd0, 1'b0});
          step_q.push_back('{car_unit, CMD_OPEN, 4'd0, 1'b0});
          step_q.push_back('{car_unit, CMD_LIGHT_OFF, fl, 1'b0});
        end
      end
      OP_OPENED: begin
        door_is_open = 1'b1;
        if (pending_stops != '0) step_q.push_back('{car_unit, CMD_CLOSE, 4'd0, 1'b0});
      end
      OP_CLOSED: begin
        door_is_open = 1'b0;
        for (int i = 0; i < NUM_FLOORS; i++) begin
          if (pending_stops[i]) begin
            if (i > car_floor) above = 1'b1;
            else if (i < car_floor) below = 1'b1;
          end
        end
        if (!above) heading_down = 1'b1;
        else if (!below) heading_down = 1'b0;
        step_q.push_back('{car_unit, heading_down ? CMD_DOWN : CMD_UP, 4'd0, 1'b0});
      end
      OP_INNER, OP_OUTER: begin
        if (fl != car_floor && in_range) begin
          if (op_v == OP_INNER) step_q.push_back('{car_unit, CMD_LIGHT_ON, fl, 1'b0});
          if (!pending_stops[fl]) begin
            pending_stops[fl] = 1'b1;
            if (door_is_open) step_q.push_back('{car_unit, CMD_CLOSE, 4'd0, 1'b0});
          end
        end
      end
      default: ;
    endcase
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) cmd_due_q.push_back(step_q[i]);
  endfunction

  // Send one event word, idling first at random, and predict on acceptance
  task automatic send_event(input logic [OP_W-1:0] op_v, input logic [FLOOR_W-1:0] fl);
    if (gaps_on) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    op       <= op_v;
    floor_no <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_commands(op_v, fl);
    events_sent++;
  endtask

  // Hold the sender until every command has come and the block has settled
  task automatic wait_car_idle();
    in_valid <= 1'b0;
    while (cmd_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_car_id(input logic [CAR_W-1:0] id);
    wait_car_idle();
    cfg_we   <= 1'b1;
    cfg_data <= id;
    @(posedge clk);
    cfg_we   <= 1'b0;
    car_unit = id;
  endtask

  // Check each command word against the oldest prediction
  always @(posedge clk) begin
    car_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cmd_due_q.size() == 0) begin
        report_mismatch("command with none pending", int'(command), -1);
      end else begin
        want = cmd_due_q.pop_front();
        if (unit !== want.unit) report_mismatch("unit", int'(unit), int'(want.unit));
        if (command !== want.cmd) report_mismatch("command", int'(command), int'(want.cmd));
        if (target_floor !== want.tgt) begin
          report_mismatch("target_floor", int'(target_floor), int'(want.tgt));
        end
        if (last !== want.last) report_mismatch("last", int'(last), int'(want.last));
      end
    end
  end

  // Walk every event, both floor extremes and each direction choice
  task automatic test_directed_events();
    send_event(OP_INIT, 4'd0);
    send_event(3'd6, 4'd15);          // undefined code, dropped
    send_event(3'd7, 4'd0);
    send_event(OP_CLOSED, 4'd0);      // nothing pending: down
    send_event(OP_INNER, 4'd0);       // button at the current floor
    send_event(OP_INNER, 4'd15);
    send_event(OP_INNER, 4'd15);      // already requested: light only
    send_event(OP_OUTER, 4'd15);      // already requested: nothing
    send_event(OP_OPENED, 4'd9);
    send_event(OP_OUTER, 4'd7);       // door open: close follows
    send_event(OP_INNER, 4'd3);
    send_event(OP_CLOSED, 4'd0);      // only above: up
    send_event(OP_ARRIVED, 4'd3);
    send_event(OP_ARRIVED, 4'd7);
    send_event(OP_ARRIVED, 4'd15);
    send_event(OP_OPENED, 4'd0);      // nothing pending
    send_event(OP_OUTER, 4'd0);
    send_event(OP_CLOSED, 4'd15);     // only below: down
    send_event(OP_INNER, 4'd10);
    send_event(OP_ARRIVED, 4'd5);     // no request here
    send_event(OP_CLOSED, 4'd0);      // both sides: keep direction
    send_event(OP_ARRIVED, 4'd0);
    send_event(OP_ARRIVED, 4'd10);
    send_event(OP_INIT, 4'd15);
  endtask

  // Step the car id through every value, extremes included
  task automatic test_car_ids();
    for (int id = 0; id < 4; id++) begin
      set_car_id(id[CAR_W-1:0]);
      send_event(OP_INIT, FLOOR_W'($urandom_range(15)));
      send_event(OP_INNER, FLOOR_W'($urandom_range(15)));
    end
  endtask

  // One well-formed trip: presses, door close, arrivals with door cycles
  task automatic run_trip();
    logic [FLOOR_W-1:0] fl;
    logic               hit;
    repeat ($urandom_range(1, 4)) begin
      send_event($urandom_range(1) ? OP_INNER : OP_OUTER, FLOOR_W'($urandom_range(15)));
    end
    send_event(OP_CLOSED, FLOOR_W'($urandom_range(15)));
    repeat ($urandom_range(1, 4)) begin
      fl = FLOOR_W'($urandom_range(15));
      if (pending_stops != '0 && $urandom_range(99) < 70) begin
        while (!pending_stops[fl]) fl = fl + FLOOR_W'(1);
      end
      hit = pending_stops[fl];
      send_event(OP_ARRIVED, fl);
      if (hit) begin
        send_event(OP_OPENED, FLOOR_W'($urandom_range(15)));
        if ($urandom_range(1)) begin
          send_event($urandom_range(1) ? OP_INNER : OP_OUTER,
                     FLOOR_W'($urandom_range(15)));
        end
        send_event(OP_CLOSED, FLOOR_W'($urandom_range(15)));
      end
    end
  endtask

  // Trips mixed with raw events, under a given car id
  task automatic test_random_trips(input logic [CAR_W-1:0] id, input int n_events);
    int start;
    set_car_id(id);
    start = events_sent;
    while (events_sent - start < n_events) begin
      if ($urandom_range(99) < 15) begin
        send_event(OP_W'($urandom_range(7)), FLOOR_W'($urandom_range(15)));
      end else begin
        run_trip();
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    op = OP_INIT;
    floor_no = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    out_stall = 1'b0;
    gaps_on = 1'b1;
    events_sent = 0;
    mismatches = 0;
    cycle_count = 0;
    pending_stops = '0;
    car_floor = '0;
    door_is_open = 1'b0;
    heading_down = 1'b0;
    car_unit = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_events();
    test_car_ids();
    test_random_trips(2'd1, 100);
    gaps_on = 1'b0;                   // long stretch at full rate
    test_random_trips(2'd2, 70);
    gaps_on = 1'b1;
    test_random_trips(2'd3, 80);
    test_random_trips(2'd0, 80);

    wait_car_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/esched_pkg.sv
rtl/esched_front.sv
rtl/esched_queue.sv
rtl/esched_back.sv
rtl/elevator_stop_scheduler.sv
rtl/esched_checker.sv
test/elevator_stop_scheduler_tb.sv
